[design/i2crts_pkg.sv]
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared codes and types for the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package i2crts_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_START   = 4'd1;
  localparam logic [PhaseW-1:0] PH_SLA_WR  = 4'd2;
  localparam logic [PhaseW-1:0] PH_REG     = 4'd3;
  localparam logic [PhaseW-1:0] PH_VAL     = 4'd4;
  localparam logic [PhaseW-1:0] PH_RESTART = 4'd5;
  localparam logic [PhaseW-1:0] PH_SLA_RD  = 4'd6;
  localparam logic [PhaseW-1:0] PH_READ    = 4'd7;
  localparam logic [PhaseW-1:0] PH_DONE    = 4'd8;
  localparam logic [PhaseW-1:0] PH_ERROR   = 4'd9;

  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] FUNC_STATUS = 2'd0;
  localparam logic [1:0] FUNC_PROBE  = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_SEND  = 3'd3;
  localparam logic [2:0] ACT_RECV  = 3'd4;

  localparam logic [1:0] COMP_BUSY  = 2'd0;
  localparam logic [1:0] COMP_DONE  = 2'd1;
  localparam logic [1:0] COMP_ERROR = 2'd2;

  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
  localparam logic [7:0] ADDR_RESET   = 8'h40;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [1:0]        kind;
    logic [7:0]        held_register;
    logic [7:0]        held_value;
    logic [7:0]        last_status;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] register_number;
    logic [7:0] write_value;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } seq_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] send_byte;
    logic [1:0] completion;
    logic [7:0] read_result;
    logic [7:0] recorded_status;
  } seq_result_t;

endpackage

[design/i2crts_step.sv]
// ----------------------------------------------------------------------------
// i2crts_step
// Next state and result for one item, from the held sequencer state.
// ----------------------------------------------------------------------------
module i2crts_step (
  input  i2crts_pkg::seq_state_t  state_i,
  input  i2crts_pkg::seq_item_t   item_i,
  input  logic [7:0]              slave_address_i,
  output i2crts_pkg::seq_state_t  state_o,
  output i2crts_pkg::seq_result_t result_o
);
  import i2crts_pkg::*;

  logic [7:0] sr;
  logic [2:0] act;
  logic [7:0] tx;
  seq_state_t nxt;

  assign sr = item_i.bus_status & STATUS_MASK;

  always_comb begin
    nxt = state_i;
    act = ACT_NONE;
    tx  = 8'h00;
    if (item_i.func == FUNC_STATUS) begin
      nxt.last_status = sr;
      case (state_i.phase)
        PH_START: begin
          if (sr == ST_START) begin
            nxt.phase = PH_SLA_WR;
            act       = ACT_SEND;
            tx        = slave_address_i;
          end else begin
            nxt.phase = PH_ERROR;
            act       = ACT_STOP;
          end
        end
        PH_SLA_WR: begin
          if (sr == ST_MT_SLA_ACK && state_i.kind == KIND_PROBE) begin
            nxt.phase = PH_DONE;
            act       = ACT_STOP;
          end else if (sr == ST_MT_SLA_ACK &&
                       (state_i.kind == KIND_WRITE || state_i.kind == KIND_READ)) begin
            nxt.phase = PH_REG;
            act       = ACT_SEND;
            tx        = state_i.held_register;
          end else begin
            nxt.phase = PH_ERROR;
            act       = ACT_STOP;
          end
        end
        PH_REG: begin
          if (sr == ST_MT_DATA_ACK && state_i.kind == KIND_WRITE) begin
            nxt.phase = PH_VAL;
            act       = ACT_SEND;
            tx        = state_i.held_value;
          end else if (sr == ST_MT_DATA_ACK && state_i.kind == KIND_READ) begin
            nxt.phase = PH_RESTART;
            act       = ACT_START;
          end else begin
            nxt.phase = PH_ERROR;
            act       = ACT_STOP;
          end
        end
        PH_VAL: begin
          nxt.phase = (sr == ST_MT_DATA_ACK && state_i.kind == KIND_WRITE) ? PH_DONE
                                                                          : PH_ERROR;
          act       = ACT_STOP;
        end
        PH_RESTART: begin
          if (sr == ST_REP_START && state_i.kind == KIND_READ) begin
            nxt.phase = PH_SLA_RD;
            act       = ACT_SEND;
            tx        = slave_address_i | ADDR_RD_BIT;
          end else begin
            nxt.phase = PH_ERROR;
            act       = ACT_STOP;
          end
        end
        PH_SLA_RD: begin
          if (sr == ST_MR_SLA_ACK && state_i.kind == KIND_READ) begin
            nxt.phase = PH_READ;
            act       = ACT_RECV;
          end else begin
            nxt.phase = PH_ERROR;
            act       = ACT_STOP;
          end
        end
        PH_READ: begin
          if (sr == ST_MR_DATA_NACK && state_i.kind == KIND_READ) begin
            nxt.held_value = item_i.received_byte;
            nxt.phase      = PH_DONE;
          end else begin
            nxt.phase = PH_ERROR;
          end
          act = ACT_STOP;
        end
        default: begin
          nxt.phase = PH_ERROR;
          act       = ACT_STOP;
        end
      endcase
    end else begin
      nxt.phase = PH_START;
      act       = ACT_START;
      case (item_i.func)
        FUNC_PROBE: nxt.kind = KIND_PROBE;
        FUNC_WRITE: begin
          nxt.kind          = KIND_WRITE;
          nxt.held_register = item_i.register_number;
          nxt.held_value    = item_i.write_value;
        end
        default: begin
          nxt.kind          = KIND_READ;
          nxt.held_register = item_i.register_number;
          nxt.held_value    = 8'h00;
        end
      endcase
    end
  end

  assign state_o                  = nxt;
  assign result_o.bus_action      = act;
  assign result_o.send_byte       = (act == ACT_SEND) ? tx : 8'h00;
  assign result_o.completion      = (nxt.phase == PH_DONE)  ? COMP_DONE  :
                                    (nxt.phase == PH_ERROR) ? COMP_ERROR : COMP_BUSY;
  assign result_o.read_result     = nxt.held_value;
  assign result_o.recorded_status = nxt.last_status;

endmodule

[design/i2c_register_transaction_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// Sequences probe, register write and register read transactions on an
// I2C master byte engine that reports standard TWI status codes.
//
// Slave side: one item per command or engine status event; tuser selects
// the function, tdata carries register number, write value, status and
// received byte. Master side: exactly one result item per input item, the
// bus action in tuser and send byte, completion, read result and recorded
// status in tdata.
// The result is valid in the cycle after its item is accepted. Throughput is
// one item per cycle while the receiver takes each result, set by the single
// result register that the state update feeds.
// If the receiver stalls, the result register holds its item and s_axis
// tready falls; it rises again in the cycle the result is taken.
// The slave address register is written through the cfg channel, which is
// always ready. Reset empties the result register, returns the sequencer to
// idle with held bytes zero and loads the slave address 0x40.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // register_number [7:0], write_value [15:8], bus_status [23:16],
  // received_byte [31:24]
  input  logic [31:0] s_axis_tdata,
  // func [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // send_byte [7:0], completion [9:8], read_result [17:10],
  // recorded_status [25:18], zero [31:26]
  output logic [31:0] m_axis_tdata,
  // bus_action [2:0]
  output logic [2:0]  m_axis_tuser
);
  import i2crts_pkg::*;

  logic [7:0]  slave_address_q;
  seq_state_t  state_q, state_d;
  seq_item_t   item;
  seq_result_t result_d, result_q;
  logic        out_valid_q;
  logic        accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item.func            = s_axis_tuser;
  assign item.register_number = s_axis_tdata[7:0];
  assign item.write_value     = s_axis_tdata[15:8];
  assign item.bus_status      = s_axis_tdata[23:16];
  assign item.received_byte   = s_axis_tdata[31:24];

  i2crts_step u_step (
    .state_i         (state_q),
    .item_i          (item),
    .slave_address_i (slave_address_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= ADDR_RESET;
    end else if (cfg_valid_i) begin
      slave_address_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_IDLE;
      state_q.kind          <= KIND_PROBE;
      state_q.held_register <= 8'h00;
      state_q.held_value    <= 8'h00;
      state_q.last_status   <= 8'h00;
      out_valid_q           <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.bus_action;
  assign m_axis_tdata  = {6'b0, result_q.recorded_status, result_q.read_result,
                          result_q.completion, result_q.send_byte};

endmodule
